// ===== src/scc_count_kosaraju_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the component counter engine.
// Each macro expects a clock named clk and a synchronous reset named rst.
// ----------------------------------------------------------------------------
`ifndef SCC_COUNT_KOSARAJU_TOP_ASSERT_SVH
`define SCC_COUNT_KOSARAJU_TOP_ASSERT_SVH

// The condition must never hold while out of reset.
`define SCC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define SCC_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ===== src/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Types and constants shared by the strongly connected component counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package scc_pkg;

  // Default capacities of the vertex and edge stores.
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_EDGES_DEF    = 4096;

  // Width of every vertex field on the ports.
  localparam int FW = 11;

  // Request codes.
  localparam logic REQ_EDGE  = 1'b0;
  localparam logic REQ_COUNT = 1'b1;

  typedef struct packed {
    logic          req_type;
    logic [FW-1:0] edge_source;
    logic [FW-1:0] edge_target;
  } cmd_t;

  typedef struct packed {
    logic [FW-1:0] component_count;
    logic          edges_dropped;
  } result_t;

  // Status from the traversal engine to the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

endpackage

// ===== src/scc_count_kosaraju_top.sv =====
// ----------------------------------------------------------------------------
// scc_count_kosaraju_top
// Strongly connected component counter using the two-pass depth-first method.
//
// Channel  | Signals                          | Transfer
// ---------+----------------------------------+------------------------------
// command  | start, busy, cmd                 | start && !busy
// result   | result_valid, result             | one-cycle strobe, no stall
// config   | cfg_valid, cfg_ready, cfg_data   | cfg_valid && cfg_ready
//
// An edge item is taken with busy staying low. A count item holds busy for
// a visited-clearing pass before each depth-first pass, for the edges examined
// by the depth-first scans (with a visited lookup where the far end is in range)
// and for each vertex, all paced by the one-read-per-cycle edge store. Every vertex scans
// the whole edge list once per pass. The result strobes in the first cycle
// with busy low. Reset is synchronous and needs no clearing pass; the result
// cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module scc_count_kosaraju_top #(
  parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = scc_pkg::MAX_EDGES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  scc_pkg::cmd_t           cmd,
  output logic                    result_valid,
  output scc_pkg::result_t        result,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [scc_pkg::FW-1:0]  cfg_data
);
  import scc_pkg::*;

  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int VW  = $clog2(MAX_VERTICES + 1);
  localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int CW  = (VW > FW) ? VW : FW;

  logic [FW-1:0] num_vertices;
  logic [EW-1:0] edge_total;
  logic          drop_flag;
  logic          go;
  logic          edge_acc;
  logic          edge_ok;
  logic [CW-1:0] n_cw, nv_cw, s_cw, t_cw, cnt_cw;
  logic [VW-1:0] n;
  logic [VW-1:0] count;
  logic [EIW-1:0] edge_ra;
  logic [2*VW-1:0] edge_q;
  eng_stat_t     stat;

  // Effective vertex count, saturated to the store capacity.
  assign nv_cw = CW'(num_vertices);
  assign n_cw  = (nv_cw > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : nv_cw;
  assign n     = n_cw[VW-1:0];

  // Command decode and edge range check.
  assign s_cw     = CW'(cmd.edge_source);
  assign t_cw     = CW'(cmd.edge_target);
  assign edge_acc = start && !busy && (cmd.req_type == REQ_EDGE);
  assign go       = start && !busy && (cmd.req_type == REQ_COUNT);
  assign edge_ok  = (edge_total != EW'(MAX_EDGES)) && (s_cw != '0) && (s_cw <= n_cw)
                    && (t_cw != '0) && (t_cw <= n_cw);

  assign busy      = stat.busy;
  assign cfg_ready = !stat.busy;

  // Configuration, edge count and drop flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_vertices <= '0;
      edge_total   <= '0;
      drop_flag    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= stat.done;
      if (cfg_valid && cfg_ready) begin
        num_vertices <= cfg_data;
      end
      if (stat.done) begin
        edge_total <= '0;
        drop_flag  <= 1'b0;
      end else if (edge_acc) begin
        if (edge_ok) begin
          edge_total <= edge_total + EW'(1);
        end else begin
          drop_flag <= 1'b1;
        end
      end
    end
  end

  // Result payload, captured as the engine finishes.
  assign cnt_cw = CW'(count);
  always_ff @(posedge clk) begin
    if (stat.done) begin
      result.component_count <= cnt_cw[FW-1:0];
      result.edges_dropped   <= drop_flag;
    end
  end

  scc_edge_store #(
    .EIW (EIW),
    .DW  (2 * VW)
  ) u_edges (
    .clk     (clk),
    .wr_en   (edge_acc && edge_ok),
    .wr_addr (edge_total[EIW-1:0]),
    .wr_data ({s_cw[VW-1:0], t_cw[VW-1:0]}),
    .rd_addr (edge_ra),
    .rd_data (edge_q)
  );

  scc_engine #(
    .MAX_VERTICES (MAX_VERTICES),
    .VW           (VW),
    .VIW          (VIW),
    .EW           (EW),
    .EIW          (EIW)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .n_in    (n),
    .etot_in (edge_total),
    .edge_ra (edge_ra),
    .edge_q  (edge_q),
    .count   (count),
    .stat    (stat)
  );

endmodule

// ===== src/scc_edge_store.sv =====
// ----------------------------------------------------------------------------
// scc_edge_store
// Edge memory: one write port for loading, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module scc_edge_store #(
  parameter int EIW = 12,
  parameter int DW  = 22
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [EIW-1:0] wr_addr,
  input  logic [DW-1:0]  wr_data,
  input  logic [EIW-1:0] rd_addr,
  output logic [DW-1:0]  rd_data
);

  localparam int DEPTH = 1 << EIW;

  logic [DW-1:0] mem [DEPTH];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/scc_engine.sv =====
// ----------------------------------------------------------------------------
// scc_engine
// Two-pass depth-first sequencer over the edge store, holding the visited
// marks, the finish order and the walk stack in local memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module scc_engine #(
  parameter int MAX_VERTICES = 1024,
  parameter int VW  = 11,
  parameter int VIW = 10,
  parameter int EW  = 13,
  parameter int EIW = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [VW-1:0]        n_in,
  input  logic [EW-1:0]        etot_in,
  output logic [EIW-1:0]       edge_ra,
  input  logic [2*VW-1:0]      edge_q,
  output logic [VW-1:0]        count,
  output scc_pkg::eng_stat_t   stat
);
  import scc_pkg::*;

  `include "scc_count_kosaraju_top_assert.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_FROOT = 4'd2;
  localparam logic [3:0] S_FCHK  = 4'd3;
  localparam logic [3:0] S_SRD   = 4'd4;
  localparam logic [3:0] S_SEDGE = 4'd5;
  localparam logic [3:0] S_SVIS  = 4'd6;
  localparam logic [3:0] S_POP   = 4'd7;
  localparam logic [3:0] S_PWAIT = 4'd8;
  localparam logic [3:0] S_RRD   = 4'd9;
  localparam logic [3:0] S_RFIN  = 4'd10;
  localparam logic [3:0] S_RVIS  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  localparam logic [VW-1:0] VMAX = VW'(MAX_VERTICES);
  localparam logic [VW-1:0] VONE = VW'(1);

  logic [3:0]    state, state_next;
  logic          rev, rev_next;
  logic [VW-1:0] n, n_next;
  logic [EW-1:0] etot, etot_next;
  logic [VW-1:0] ci, ci_next;
  logic [VW-1:0] cur_u, cur_u_next;
  logic [EW-1:0] cur_k, cur_k_next;
  logic [VW-1:0] depth, depth_next;
  logic [VW-1:0] ft, ft_next;
  logic [VW-1:0] cnt, cnt_next;
  logic [VW-1:0] b_reg, b_next;

  // Memory ports.
  logic           vis_we, vis_wd, vis_q;
  logic [VIW-1:0] vis_wa, vis_ra;
  logic           fin_we;
  logic [VIW-1:0] fin_wa, fin_ra;
  logic [VW-1:0]  fin_wd, fin_q;
  logic           stk_we;
  logic [VIW-1:0] stk_wa, stk_ra;
  logic [VW+EW-1:0] stk_wd, stk_q;

  logic           vis_mem [MAX_VERTICES];
  logic [VW-1:0]  fin_mem [MAX_VERTICES];
  logic [VW+EW-1:0] stk_mem [MAX_VERTICES];

  // Sequencer next-state logic and memory port control.
  always_comb begin
    logic [VW-1:0] ea, eb, eb_m1, bm1, dm1, dm2, ftm1, fqm1;
    ea    = rev ? edge_q[VW-1:0] : edge_q[2*VW-1:VW];
    eb    = rev ? edge_q[2*VW-1:VW] : edge_q[VW-1:0];
    eb_m1 = eb - VONE;
    bm1   = b_reg - VONE;
    dm1   = depth - VONE;
    dm2   = depth - VW'(2);
    ftm1  = ft - VONE;
    fqm1  = fin_q - VONE;

    state_next = state;
    rev_next   = rev;
    n_next     = n;
    etot_next  = etot;
    ci_next    = ci;
    cur_u_next = cur_u;
    cur_k_next = cur_k;
    depth_next = depth;
    ft_next    = ft;
    cnt_next   = cnt;
    b_next     = b_reg;
    vis_we = 1'b0; vis_wa = '0; vis_wd = 1'b0; vis_ra = '0;
    fin_we = 1'b0; fin_wa = '0; fin_wd = cur_u; fin_ra = '0;
    stk_we = 1'b0; stk_wa = dm1[VIW-1:0]; stk_wd = {cur_u, cur_k}; stk_ra = '0;
    edge_ra = cur_k[EIW-1:0];

    unique case (state)
      S_IDLE: begin
        if (go) begin
          n_next     = n_in;
          etot_next  = etot_in;
          rev_next   = 1'b0;
          ci_next    = '0;
          ft_next    = '0;
          cnt_next   = '0;
          state_next = S_CLR;
        end
      end
      S_CLR: begin
        if (ci == n) begin
          ci_next    = '0;
          state_next = rev ? S_RRD : S_FROOT;
        end else begin
          vis_we  = 1'b1;
          vis_wa  = ci[VIW-1:0];
          ci_next = ci + VONE;
        end
      end
      S_FROOT: begin
        if (ci == n) begin
          rev_next   = 1'b1;
          ci_next    = '0;
          state_next = S_CLR;
        end else begin
          vis_ra     = ci[VIW-1:0];
          state_next = S_FCHK;
        end
      end
      S_FCHK: begin
        if (vis_q) begin
          ci_next    = ci + VONE;
          state_next = S_FROOT;
        end else begin
          vis_we     = 1'b1;
          vis_wa     = ci[VIW-1:0];
          vis_wd     = 1'b1;
          cur_u_next = ci + VONE;
          cur_k_next = '0;
          depth_next = VONE;
          state_next = S_SRD;
        end
      end
      S_SRD: begin
        state_next = (cur_k == etot) ? S_POP : S_SEDGE;
      end
      S_SEDGE: begin
        cur_k_next = cur_k + EW'(1);
        if (ea == cur_u && eb != '0 && eb <= n) begin
          b_next     = eb;
          vis_ra     = eb_m1[VIW-1:0];
          state_next = S_SVIS;
        end else begin
          state_next = S_SRD;
        end
      end
      S_SVIS: begin
        if (vis_q) begin
          state_next = S_SRD;
        end else if (depth != VMAX) begin
          stk_we     = 1'b1;
          vis_we     = 1'b1;
          vis_wa     = bm1[VIW-1:0];
          vis_wd     = 1'b1;
          cur_u_next = b_reg;
          cur_k_next = '0;
          depth_next = depth + VONE;
          state_next = S_SRD;
        end else begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        if (!rev && ft != VMAX) begin
          fin_we  = 1'b1;
          fin_wa  = ft[VIW-1:0];
          ft_next = ft + VONE;
        end
        depth_next = dm1;
        if (depth == VONE) begin
          if (rev) begin
            state_next = S_RRD;
          end else begin
            ci_next    = ci + VONE;
            state_next = S_FROOT;
          end
        end else begin
          stk_ra     = dm2[VIW-1:0];
          state_next = S_PWAIT;
        end
      end
      S_PWAIT: begin
        cur_u_next = stk_q[VW+EW-1:EW];
        cur_k_next = stk_q[EW-1:0];
        state_next = S_SRD;
      end
      S_RRD: begin
        if (ft == '0) begin
          state_next = S_DONE;
        end else begin
          ft_next    = ftm1;
          fin_ra     = ftm1[VIW-1:0];
          state_next = S_RFIN;
        end
      end
      S_RFIN: begin
        vis_ra     = fqm1[VIW-1:0];
        b_next     = fin_q;
        state_next = S_RVIS;
      end
      S_RVIS: begin
        if (vis_q) begin
          state_next = S_RRD;
        end else begin
          cnt_next   = cnt + VONE;
          vis_we     = 1'b1;
          vis_wa     = bm1[VIW-1:0];
          vis_wd     = 1'b1;
          cur_u_next = b_reg;
          cur_k_next = '0;
          depth_next = VONE;
          state_next = S_SRD;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      depth <= '0;
      ft    <= '0;
    end else begin
      state <= state_next;
      depth <= depth_next;
      ft    <= ft_next;
    end
    rev   <= rev_next;
    n     <= n_next;
    etot  <= etot_next;
    ci    <= ci_next;
    cur_u <= cur_u_next;
    cur_k <= cur_k_next;
    cnt   <= cnt_next;
    b_reg <= b_next;
  end

  // Visited marks, finish order and walk stack memories.
  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    vis_q <= vis_mem[vis_ra];
    if (fin_we) begin
      fin_mem[fin_wa] <= fin_wd;
    end
    fin_q <= fin_mem[fin_ra];
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_q <= stk_mem[stk_ra];
  end

  assign count     = cnt;
  assign stat.busy = (state != S_IDLE);
  assign stat.done = (state == S_DONE);

  `SCC_NEVER(a_depth_cap, (state != S_IDLE) && (depth > VMAX), "walk depth beyond capacity")
  `SCC_NEVER(a_fin_cap, ft > VMAX, "finish order beyond capacity")
  `SCC_NEXT(a_done_idle, state == S_DONE, state == S_IDLE, "engine not idle after done")

endmodule
